[hdl/vpen_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vpen_pkg;

   // Sample format and data set size.
   localparam int SAMPLE_BITS = 24;
   localparam int MAX_CELLS   = 4096;

   // Port widths of the request and response channels.
   localparam int IN_W       = 24;
   localparam int L1_OUT_W   = 38;
   localparam int RMS_OUT_W  = 31;
   localparam int PEAK_OUT_W = 24;
   localparam int REL_W      = 32;
   localparam int FRAC_BITS  = 16;

   // Magnitude of a component difference and of a reference component.
   localparam int MAG_W  = SAMPLE_BITS + 1;
   localparam int RMAG_W = SAMPLE_BITS;
   localparam int PROD_W = 2 * MAG_W;
   localparam int PSUM_W = PROD_W + 1;

   // L1 accumulators hold the limit plus one more cell without wrapping.
   localparam int L1_W = $clog2(MAX_CELLS) + SAMPLE_BITS + 3;
   localparam logic [L1_W-1:0] L1_LIMIT = L1_W'(MAX_CELLS) << (SAMPLE_BITS + 1);

   localparam int SQ_W   = 64;
   localparam int ROOT_W = SQ_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam logic [RMS_OUT_W-1:0] ROOT_LIMIT = {RMS_OUT_W{1'b1}};

   // Divider: numerator is a 38-bit value shifted up by the fraction bits.
   localparam int NUM_W  = L1_OUT_W + FRAC_BITS;
   localparam int DEN_W  = (L1_W > RMS_OUT_W) ? L1_W : RMS_OUT_W;
   localparam int STEP_W = $clog2(NUM_W);

   // Queue of finished data sets between the front and the back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [L1_W-1:0]   dsum;
      logic [SQ_W-1:0]   dsq;
      logic [MAG_W-1:0]  dpeak;
      logic [L1_W-1:0]   rsum;
      logic [SQ_W-1:0]   rsq;
      logic [RMAG_W-1:0] rpeak;
      logic              ovf;
   } snap_type;

endpackage

`default_nettype wire

[hdl/vpen_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module vpen_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     take,
   input  wire logic [vpen_pkg::IN_W-1:0] test_first,
   input  wire logic [vpen_pkg::IN_W-1:0] test_second,
   input  wire logic [vpen_pkg::IN_W-1:0] ref_first,
   input  wire logic [vpen_pkg::IN_W-1:0] ref_second,
   input  wire logic                     last_item,
   output logic                          push,
   output vpen_pkg::snap_type            snap
);

   localparam int SB     = vpen_pkg::SAMPLE_BITS;
   localparam int MAG_W  = vpen_pkg::MAG_W;
   localparam int RMAG_W = vpen_pkg::RMAG_W;
   localparam int PROD_W = vpen_pkg::PROD_W;
   localparam int PSUM_W = vpen_pkg::PSUM_W;
   localparam int L1_W   = vpen_pkg::L1_W;
   localparam int SQ_W   = vpen_pkg::SQ_W;

   logic [SB-1:0] tf, ts, rf, rs;
   logic [SB:0]   dfd, dsd, rfe, rse;
   logic [MAG_W-1:0] df, ds, af_full, as_full;

   // Stage A: magnitudes.
   logic              a_vld_ff, a_last_ff;
   logic [MAG_W-1:0]  a_df_ff, a_ds_ff;
   logic [RMAG_W-1:0] a_af_ff, a_as_ff;

   // Stage B: squares, pair sums and pair maxima.
   logic              b_vld_ff, b_last_ff;
   logic [PROD_W-1:0] b_dp1_ff, b_dp2_ff, b_rp1_ff, b_rp2_ff;
   logic [MAG_W:0]    b_dl1_ff;
   logic [RMAG_W:0]   b_rl1_ff;
   logic [MAG_W-1:0]  b_dmax_ff;
   logic [RMAG_W-1:0] b_rmax_ff;

   // Stage C: summed squares.
   logic              c_vld_ff, c_last_ff;
   logic [PSUM_W-1:0] c_dps_ff, c_rps_ff;
   logic [MAG_W:0]    c_dl1_ff;
   logic [RMAG_W:0]   c_rl1_ff;
   logic [MAG_W-1:0]  c_dmax_ff;
   logic [RMAG_W-1:0] c_rmax_ff;

   // Accumulators.
   logic [L1_W-1:0]   dsum_ff, rsum_ff;
   logic [SQ_W-1:0]   dsq_ff, rsq_ff;
   logic [MAG_W-1:0]  dpeak_ff;
   logic [RMAG_W-1:0] rpeak_ff;
   logic              ovf_ff;

   logic [L1_W-1:0]   dsum_add, rsum_add;
   logic [SQ_W:0]     dsq_add, rsq_add;
   logic              dsum_sat, rsum_sat;
   vpen_pkg::snap_type next_acc;

   // Components are the low SAMPLE_BITS bits, sign-extended from there.
   assign tf = SB'(test_first);
   assign ts = SB'(test_second);
   assign rf = SB'(ref_first);
   assign rs = SB'(ref_second);

   assign dfd = {tf[SB-1], tf} - {rf[SB-1], rf};
   assign dsd = {ts[SB-1], ts} - {rs[SB-1], rs};
   assign rfe = {rf[SB-1], rf};
   assign rse = {rs[SB-1], rs};

   assign df      = dfd[SB] ? (~dfd + 1'b1) : dfd;
   assign ds      = dsd[SB] ? (~dsd + 1'b1) : dsd;
   assign af_full = rfe[SB] ? (~rfe + 1'b1) : rfe;
   assign as_full = rse[SB] ? (~rse + 1'b1) : rse;

   always_comb begin
      dsum_add = dsum_ff + L1_W'(c_dl1_ff);
      rsum_add = rsum_ff + L1_W'(c_rl1_ff);
      dsum_sat = dsum_add > vpen_pkg::L1_LIMIT;
      rsum_sat = rsum_add > vpen_pkg::L1_LIMIT;
      dsq_add  = {1'b0, dsq_ff} + (SQ_W+1)'(c_dps_ff);
      rsq_add  = {1'b0, rsq_ff} + (SQ_W+1)'(c_rps_ff);

      next_acc.dsum  = dsum_sat ? vpen_pkg::L1_LIMIT : dsum_add;
      next_acc.rsum  = rsum_sat ? vpen_pkg::L1_LIMIT : rsum_add;
      next_acc.dsq   = dsq_add[SQ_W] ? {SQ_W{1'b1}} : dsq_add[SQ_W-1:0];
      next_acc.rsq   = rsq_add[SQ_W] ? {SQ_W{1'b1}} : rsq_add[SQ_W-1:0];
      next_acc.dpeak = (c_dmax_ff > dpeak_ff) ? c_dmax_ff : dpeak_ff;
      next_acc.rpeak = (c_rmax_ff > rpeak_ff) ? c_rmax_ff : rpeak_ff;
      next_acc.ovf   = ovf_ff | dsum_sat | rsum_sat | dsq_add[SQ_W] | rsq_add[SQ_W];
   end

   assign push = c_vld_ff & c_last_ff;
   assign snap = next_acc;

   always_ff @(posedge clock) begin
      a_df_ff   <= df;
      a_ds_ff   <= ds;
      a_af_ff   <= RMAG_W'(af_full);
      a_as_ff   <= RMAG_W'(as_full);
      a_last_ff <= last_item;

      b_dp1_ff  <= a_df_ff * a_df_ff;
      b_dp2_ff  <= a_ds_ff * a_ds_ff;
      b_rp1_ff  <= PROD_W'(a_af_ff) * PROD_W'(a_af_ff);
      b_rp2_ff  <= PROD_W'(a_as_ff) * PROD_W'(a_as_ff);
      b_dl1_ff  <= (MAG_W+1)'(a_df_ff) + (MAG_W+1)'(a_ds_ff);
      b_rl1_ff  <= (RMAG_W+1)'(a_af_ff) + (RMAG_W+1)'(a_as_ff);
      b_dmax_ff <= (a_ds_ff > a_df_ff) ? a_ds_ff : a_df_ff;
      b_rmax_ff <= (a_as_ff > a_af_ff) ? a_as_ff : a_af_ff;
      b_last_ff <= a_last_ff;

      c_dps_ff  <= PSUM_W'(b_dp1_ff) + PSUM_W'(b_dp2_ff);
      c_rps_ff  <= PSUM_W'(b_rp1_ff) + PSUM_W'(b_rp2_ff);
      c_dl1_ff  <= b_dl1_ff;
      c_rl1_ff  <= b_rl1_ff;
      c_dmax_ff <= b_dmax_ff;
      c_rmax_ff <= b_rmax_ff;
      c_last_ff <= b_last_ff;

      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         dsum_ff  <= '0;
         rsum_ff  <= '0;
         dsq_ff   <= '0;
         rsq_ff   <= '0;
         dpeak_ff <= '0;
         rpeak_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         a_vld_ff <= take;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         if (c_vld_ff) begin
            if (c_last_ff) begin
               // The finished set leaves through the queue; start a fresh one.
               dsum_ff  <= '0;
               rsum_ff  <= '0;
               dsq_ff   <= '0;
               rsq_ff   <= '0;
               dpeak_ff <= '0;
               rpeak_ff <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               dsum_ff  <= next_acc.dsum;
               rsum_ff  <= next_acc.rsum;
               dsq_ff   <= next_acc.dsq;
               rsq_ff   <= next_acc.rsq;
               dpeak_ff <= next_acc.dpeak;
               rpeak_ff <= next_acc.rpeak;
               ovf_ff   <= next_acc.ovf;
            end
         end
      end
   end

endmodule

`default_nettype wire

[hdl/vpen_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module vpen_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  vpen_pkg::snap_type      wdata,
   input  wire logic               pop,
   output vpen_pkg::snap_type      rdata,
   output logic                    empty
);

   vpen_pkg::snap_type               mem_ff [vpen_pkg::QDEPTH];
   logic [vpen_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [vpen_pkg::QCNT_W-1:0]      count_ff;

   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[hdl/vpen_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module vpen_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_empty,
   input  vpen_pkg::snap_type                      q_head,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   output logic [vpen_pkg::L1_OUT_W-1:0]           rsp_abs_sum_err,
   output logic [vpen_pkg::RMS_OUT_W-1:0]          rsp_abs_rms_err,
   output logic [vpen_pkg::PEAK_OUT_W-1:0]         rsp_abs_peak_err,
   output logic [vpen_pkg::REL_W-1:0]              rsp_rel_sum_err,
   output logic [vpen_pkg::REL_W-1:0]              rsp_rel_rms_err,
   output logic [vpen_pkg::REL_W-1:0]              rsp_rel_peak_err,
   output logic [vpen_pkg::L1_OUT_W-1:0]           rsp_ref_sum_norm,
   output logic [vpen_pkg::RMS_OUT_W-1:0]          rsp_ref_rms_norm,
   output logic [vpen_pkg::PEAK_OUT_W-1:0]         rsp_ref_peak_norm,
   output logic                                    rsp_zero_reference,
   output logic                                    rsp_sum_saturated
);

   localparam int SQ_W      = vpen_pkg::SQ_W;
   localparam int ROOT_W    = vpen_pkg::ROOT_W;
   localparam int REM_W     = vpen_pkg::REM_W;
   localparam int NUM_W     = vpen_pkg::NUM_W;
   localparam int DEN_W     = vpen_pkg::DEN_W;
   localparam int STEP_W    = vpen_pkg::STEP_W;
   localparam int REL_W     = vpen_pkg::REL_W;
   localparam int RMS_W     = vpen_pkg::RMS_OUT_W;
   localparam int L1O_W     = vpen_pkg::L1_OUT_W;
   localparam int FRAC      = vpen_pkg::FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT_ERR,
      ST_ROOT_REF,
      ST_DIV_SUM,
      ST_DIV_RMS,
      ST_DIV_PEAK
   } state_type;

   state_type           state_ff;
   vpen_pkg::snap_type  snap_ff;
   logic [STEP_W-1:0]   step_ff;

   // Shared square root unit for both roots, which run one after the other.
   logic [SQ_W-1:0]     sq_x_ff;
   logic [REM_W-1:0]    sq_rem_ff;
   logic [ROOT_W-1:0]   sq_root_ff;

   // Shared restoring divider, one quotient bit per cycle.
   logic [NUM_W-1:0]    dv_num_ff;
   logic [DEN_W-1:0]    dv_rem_ff;
   logic [DEN_W-1:0]    dv_den_ff;
   logic [NUM_W-1:0]    dv_q_ff;

   logic [RMS_W-1:0]    a_rms_ff, r_rms_ff;
   logic [REL_W-1:0]    rel_sum_ff, rel_rms_ff;
   logic                sat_ff, zero_ff;

   logic                                rsp_valid_ff;
   logic [L1O_W-1:0]                    abs_sum_ff, ref_sum_ff;
   logic [RMS_W-1:0]                    abs_rms_ff, ref_rms_ff;
   logic [vpen_pkg::PEAK_OUT_W-1:0]     abs_peak_ff, ref_peak_ff;
   logic [REL_W-1:0]                    rel_sum_o_ff, rel_rms_o_ff, rel_peak_o_ff;
   logic                                zero_o_ff, sat_o_ff;

   logic [REM_W+1:0]    sq_rem_sh, sq_trial;
   logic                sq_ge;
   logic [REM_W-1:0]    sq_rem_in;
   logic [ROOT_W-1:0]   sq_root_in;
   logic [RMS_W-1:0]    root_clamped;
   logic                root_over;

   logic [DEN_W:0]      dv_rem_sh;
   logic                dv_ge;
   logic [DEN_W-1:0]    dv_rem_in;
   logic [NUM_W-1:0]    dv_q_in;
   logic                den_zero;
   logic [REL_W-1:0]    rel_value;

   always_comb begin
      sq_rem_sh    = {sq_rem_ff, sq_x_ff[SQ_W-1 -: 2]};
      sq_trial     = {2'b00, sq_root_ff, 2'b01};
      sq_ge        = sq_rem_sh >= sq_trial;
      sq_rem_in    = sq_ge ? REM_W'(sq_rem_sh - sq_trial) : REM_W'(sq_rem_sh);
      sq_root_in   = {sq_root_ff[ROOT_W-2:0], sq_ge};
      root_over    = sq_root_in[ROOT_W-1];
      root_clamped = root_over ? vpen_pkg::ROOT_LIMIT : RMS_W'(sq_root_in);

      dv_rem_sh = {dv_rem_ff, dv_num_ff[NUM_W-1]};
      dv_ge     = dv_rem_sh >= {1'b0, dv_den_ff};
      dv_rem_in = dv_ge ? DEN_W'(dv_rem_sh - {1'b0, dv_den_ff}) : DEN_W'(dv_rem_sh);
      dv_q_in   = {dv_q_ff[NUM_W-2:0], dv_ge};
      den_zero  = (dv_den_ff == '0);
      if (den_zero || (dv_q_in[NUM_W-1:REL_W] != '0)) begin
         rel_value = {REL_W{1'b1}};
      end else begin
         rel_value = dv_q_in[REL_W-1:0];
      end
   end

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DIV_PEAK) && (step_ff == '0);
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  snap_ff    <= q_head;
                  sq_x_ff    <= q_head.dsq;
                  sq_rem_ff  <= '0;
                  sq_root_ff <= '0;
                  step_ff    <= STEP_W'(ROOT_W - 1);
                  sat_ff     <= 1'b0;
                  zero_ff    <= 1'b0;
                  state_ff   <= ST_ROOT_ERR;
               end
            end
            ST_ROOT_ERR, ST_ROOT_REF: begin
               if (step_ff == '0) begin
                  sat_ff     <= sat_ff | root_over;
                  sq_x_ff    <= snap_ff.rsq;
                  sq_rem_ff  <= '0;
                  sq_root_ff <= '0;
                  if (state_ff == ST_ROOT_ERR) begin
                     a_rms_ff <= root_clamped;
                     step_ff  <= STEP_W'(ROOT_W - 1);
                     state_ff <= ST_ROOT_REF;
                  end else begin
                     r_rms_ff  <= root_clamped;
                     dv_num_ff <= {L1O_W'(snap_ff.dsum), FRAC'(0)};
                     dv_den_ff <= DEN_W'(snap_ff.rsum);
                     dv_rem_ff <= '0;
                     dv_q_ff   <= '0;
                     step_ff   <= STEP_W'(NUM_W - 1);
                     state_ff  <= ST_DIV_SUM;
                  end
               end else begin
                  sq_x_ff    <= sq_x_ff << 2;
                  sq_rem_ff  <= sq_rem_in;
                  sq_root_ff <= sq_root_in;
                  step_ff    <= step_ff - 1'b1;
               end
            end
            ST_DIV_SUM, ST_DIV_RMS, ST_DIV_PEAK: begin
               if (step_ff == '0) begin
                  zero_ff   <= zero_ff | den_zero;
                  dv_rem_ff <= '0;
                  dv_q_ff   <= '0;
                  step_ff   <= STEP_W'(NUM_W - 1);
                  if (state_ff == ST_DIV_SUM) begin
                     rel_sum_ff <= rel_value;
                     dv_num_ff  <= {L1O_W'(a_rms_ff), FRAC'(0)};
                     dv_den_ff  <= DEN_W'(r_rms_ff);
                     state_ff   <= ST_DIV_RMS;
                  end else if (state_ff == ST_DIV_RMS) begin
                     rel_rms_ff <= rel_value;
                     dv_num_ff  <= {L1O_W'(snap_ff.dpeak), FRAC'(0)};
                     dv_den_ff  <= DEN_W'(snap_ff.rpeak);
                     state_ff   <= ST_DIV_PEAK;
                  end else begin
                     abs_sum_ff    <= L1O_W'(snap_ff.dsum);
                     abs_rms_ff    <= a_rms_ff;
                     abs_peak_ff   <= vpen_pkg::PEAK_OUT_W'(snap_ff.dpeak);
                     rel_sum_o_ff  <= rel_sum_ff;
                     rel_rms_o_ff  <= rel_rms_ff;
                     rel_peak_o_ff <= rel_value;
                     ref_sum_ff    <= L1O_W'(snap_ff.rsum);
                     ref_rms_ff    <= r_rms_ff;
                     ref_peak_ff   <= vpen_pkg::PEAK_OUT_W'(snap_ff.rpeak);
                     zero_o_ff     <= zero_ff | den_zero;
                     sat_o_ff      <= snap_ff.ovf | sat_ff;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  dv_num_ff <= dv_num_ff << 1;
                  dv_rem_ff <= dv_rem_in;
                  dv_q_ff   <= dv_q_in;
                  step_ff   <= step_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_abs_sum_err    = abs_sum_ff;
   assign rsp_abs_rms_err    = abs_rms_ff;
   assign rsp_abs_peak_err   = abs_peak_ff;
   assign rsp_rel_sum_err    = rel_sum_o_ff;
   assign rsp_rel_rms_err    = rel_rms_o_ff;
   assign rsp_rel_peak_err   = rel_peak_o_ff;
   assign rsp_ref_sum_norm   = ref_sum_ff;
   assign rsp_ref_rms_norm   = ref_rms_ff;
   assign rsp_ref_peak_norm  = ref_peak_ff;
   assign rsp_zero_reference = zero_o_ff;
   assign rsp_sum_saturated  = sat_o_ff;

`ifndef SYNTHESIS
   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_zero_rms_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_ref_rms_norm == '0)) |-> rsp_zero_reference)
      else $error("zero reference L2 norm without zero_reference flag");

   a_zero_rms_ones : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_ref_rms_norm == '0)) |-> (rsp_rel_rms_err == {REL_W{1'b1}}))
      else $error("relative L2 error not all ones for zero reference");

   a_pop_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_ROOT_ERR))
      else $error("queue popped without starting the square roots");
`endif

endmodule

`default_nettype wire

[hdl/vector_pair_error_norms_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Error norms between a test vector set and a reference vector set.
//
// Request channel: a cell (two test and two reference components, signed
// Q8.16, plus last_item) is transferred at each rising edge where start is
// high and busy is low. Cells may be transferred in every cycle.
// Each cell enters a three-stage front pipeline that forms magnitudes,
// squares and pair sums and then updates the L1, squared and peak
// accumulators. A cell marked last closes its data set: the accumulated
// totals go into a four-entry queue and the accumulators start over.
// The back end takes one finished set at a time from the queue and runs a
// shared square root unit (two roots) and a shared restoring divider
// (three quotients), and it pops the next set only once it is idle again.
// The response for a set is marked on the rsp_ ports by rsp_valid for
// exactly one cycle; the receiver cannot stall it.
// busy rises only when four closed sets are waiting or in flight; ordinary
// cells are never held off otherwise.
// A synchronous reset clears the accumulators, the queue and the back end;
// results in progress are dropped.

module vector_pair_error_norms_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [vpen_pkg::IN_W-1:0]         req_test_first,
   input  wire logic [vpen_pkg::IN_W-1:0]         req_test_second,
   input  wire logic [vpen_pkg::IN_W-1:0]         req_ref_first,
   input  wire logic [vpen_pkg::IN_W-1:0]         req_ref_second,
   input  wire logic                              req_last_item,
   output logic                                   rsp_valid,
   output logic [vpen_pkg::L1_OUT_W-1:0]          rsp_abs_sum_err,
   output logic [vpen_pkg::RMS_OUT_W-1:0]         rsp_abs_rms_err,
   output logic [vpen_pkg::PEAK_OUT_W-1:0]        rsp_abs_peak_err,
   output logic [vpen_pkg::REL_W-1:0]             rsp_rel_sum_err,
   output logic [vpen_pkg::REL_W-1:0]             rsp_rel_rms_err,
   output logic [vpen_pkg::REL_W-1:0]             rsp_rel_peak_err,
   output logic [vpen_pkg::L1_OUT_W-1:0]          rsp_ref_sum_norm,
   output logic [vpen_pkg::RMS_OUT_W-1:0]         rsp_ref_rms_norm,
   output logic [vpen_pkg::PEAK_OUT_W-1:0]        rsp_ref_peak_norm,
   output logic                                   rsp_zero_reference,
   output logic                                   rsp_sum_saturated
);

   logic                          take;
   logic                          push, pop, q_empty;
   vpen_pkg::snap_type            push_data, head_data;
   logic [vpen_pkg::QCNT_W-1:0]   pend_ff;

   // Closed sets counted from the transfer of their last cell until the
   // back end pops them, so the queue can never overflow.
   assign busy = (pend_ff == vpen_pkg::QCNT_W'(vpen_pkg::QDEPTH));
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         if ((take && req_last_item) && !pop) begin
            pend_ff <= pend_ff + 1'b1;
         end else if (pop && !(take && req_last_item)) begin
            pend_ff <= pend_ff - 1'b1;
         end
      end
   end

   vpen_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .test_first  (req_test_first),
      .test_second (req_test_second),
      .ref_first   (req_ref_first),
      .ref_second  (req_ref_second),
      .last_item   (req_last_item),
      .push        (push),
      .snap        (push_data)
   );

   vpen_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_data),
      .pop   (pop),
      .rdata (head_data),
      .empty (q_empty)
   );

   vpen_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (head_data),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_abs_sum_err    (rsp_abs_sum_err),
      .rsp_abs_rms_err    (rsp_abs_rms_err),
      .rsp_abs_peak_err   (rsp_abs_peak_err),
      .rsp_rel_sum_err    (rsp_rel_sum_err),
      .rsp_rel_rms_err    (rsp_rel_rms_err),
      .rsp_rel_peak_err   (rsp_rel_peak_err),
      .rsp_ref_sum_norm   (rsp_ref_sum_norm),
      .rsp_ref_rms_norm   (rsp_ref_rms_norm),
      .rsp_ref_peak_norm  (rsp_ref_peak_norm),
      .rsp_zero_reference (rsp_zero_reference),
      .rsp_sum_saturated  (rsp_sum_saturated)
   );

endmodule

`default_nettype wire

[tb/sv/tb_vector_pair_error_norms_top.sv]
`timescale 1ns / 1ps

module tb_vector_pair_error_norms_top;

   // One cell of a data set as the sender holds it. The two flags steer the
   // driver: drain_first holds the cell back until every pending result has
   // come, and no_idle suppresses random gaps in front of it.
   typedef struct {
      logic [vpen_pkg::IN_W-1:0] test_first;
      logic [vpen_pkg::IN_W-1:0] test_second;
      logic [vpen_pkg::IN_W-1:0] ref_first;
      logic [vpen_pkg::IN_W-1:0] ref_second;
      logic                      last_item;
      bit                        drain_first;
      bit                        no_idle;
   } cell_type;

   // The norms expected for one closed data set.
   typedef struct {
      logic [vpen_pkg::L1_OUT_W-1:0]   abs_sum_err;
      logic [vpen_pkg::RMS_OUT_W-1:0]  abs_rms_err;
      logic [vpen_pkg::PEAK_OUT_W-1:0] abs_peak_err;
      logic [vpen_pkg::REL_W-1:0]      rel_sum_err;
      logic [vpen_pkg::REL_W-1:0]      rel_rms_err;
      logic [vpen_pkg::REL_W-1:0]      rel_peak_err;
      logic [vpen_pkg::L1_OUT_W-1:0]   ref_sum_norm;
      logic [vpen_pkg::RMS_OUT_W-1:0]  ref_rms_norm;
      logic [vpen_pkg::PEAK_OUT_W-1:0] ref_peak_norm;
      logic                            zero_reference;
      logic                            sum_saturated;
   } norms_type;

   localparam logic [63:0] L1_CAP     =
      64'(vpen_pkg::MAX_CELLS) << (vpen_pkg::SAMPLE_BITS + 1);
   localparam logic [63:0] ROOT_CAP   = 64'h7FFF_FFFF;
   localparam logic [63:0] QUOT_CAP   = 64'hFFFF_FFFF;
   localparam logic [63:0] NUM_MASK   = (64'd1 << vpen_pkg::L1_OUT_W) - 64'd1;
   localparam int          DRAIN_WAIT = 400;
   localparam longint      CYCLE_LIMIT = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [vpen_pkg::IN_W-1:0] req_test_first  = '0;
   logic [vpen_pkg::IN_W-1:0] req_test_second = '0;
   logic [vpen_pkg::IN_W-1:0] req_ref_first   = '0;
   logic [vpen_pkg::IN_W-1:0] req_ref_second  = '0;
   logic                      req_last_item   = 1'b0;
   logic                            rsp_valid;
   logic [vpen_pkg::L1_OUT_W-1:0]   rsp_abs_sum_err;
   logic [vpen_pkg::RMS_OUT_W-1:0]  rsp_abs_rms_err;
   logic [vpen_pkg::PEAK_OUT_W-1:0] rsp_abs_peak_err;
   logic [vpen_pkg::REL_W-1:0]      rsp_rel_sum_err;
   logic [vpen_pkg::REL_W-1:0]      rsp_rel_rms_err;
   logic [vpen_pkg::REL_W-1:0]      rsp_rel_peak_err;
   logic [vpen_pkg::L1_OUT_W-1:0]   rsp_ref_sum_norm;
   logic [vpen_pkg::RMS_OUT_W-1:0]  rsp_ref_rms_norm;
   logic [vpen_pkg::PEAK_OUT_W-1:0] rsp_ref_peak_norm;
   logic                            rsp_zero_reference;
   logic                            rsp_sum_saturated;

   vector_pair_error_norms_top uut (.*);

   // The clock toggles every nanosecond, giving a 2 ns period.
   always #1 clock = ~clock;

   cell_type  pending_cells[$];
   norms_type expected_norms[$];
   int        mismatch_count = 0;
   longint    cycle_count    = 0;

   // Running totals of the open data set, kept at full 64-bit width so the
   // saturation points can be checked against the exact limits.
   logic [63:0] err_l1, err_sq, err_peak;
   logic [63:0] refl1, refsq, refpeak;
   bit          accum_overflow;

   initial begin
      err_l1 = 0; err_sq = 0; err_peak = 0;
      refl1 = 0; refsq = 0; refpeak = 0;
      accum_overflow = 0;
   end

   function automatic logic [63:0] magnitude(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   // Floor of the square root, one result bit per iteration.
   function automatic logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= x) r = trial;
      end
      return r;
   endfunction

   function automatic logic [63:0] l1_add(logic [63:0] acc, logic [63:0] a);
      logic [63:0] s;
      s = acc + a;
      if (s > L1_CAP) begin
         s = L1_CAP;
         accum_overflow = 1;
      end
      return s;
   endfunction

   function automatic logic [63:0] sq_add(logic [63:0] acc, logic [63:0] a);
      logic [64:0] s;
      s = {1'b0, acc} + {1'b0, a};
      if (s[64]) begin
         accum_overflow = 1;
         return '1;
      end
      return s[63:0];
   endfunction

   // Relative error in Q16.16; a zero divisor gives all ones and raises the flag.
   function automatic logic [63:0] ratio(logic [63:0] num, logic [63:0] den, ref bit zero);
      logic [63:0] q;
      if (den == 0) begin
         zero = 1;
         return QUOT_CAP;
      end
      q = ((num & NUM_MASK) << vpen_pkg::FRAC_BITS) / den;
      return (q > QUOT_CAP) ? QUOT_CAP : q;
   endfunction

   // Folds one transferred cell into the open set and, for a closing cell,
   // queues the norms of the whole set.
   function automatic void accumulate_cell(cell_type c);
      longint tf, ts, rf, rs;
      logic [63:0] df, ds, af, as, a_rms, r_rms;
      bit sat, zero;
      norms_type n;
      tf = $signed(c.test_first);
      ts = $signed(c.test_second);
      rf = $signed(c.ref_first);
      rs = $signed(c.ref_second);
      df = magnitude(tf - rf);
      ds = magnitude(ts - rs);
      af = magnitude(rf);
      as = magnitude(rs);
      err_l1 = l1_add(err_l1, df + ds);
      refl1  = l1_add(refl1, af + as);
      err_sq = sq_add(err_sq, df * df + ds * ds);
      refsq  = sq_add(refsq, af * af + as * as);
      if (df > err_peak) err_peak = df;
      if (ds > err_peak) err_peak = ds;
      if (af > refpeak) refpeak = af;
      if (as > refpeak) refpeak = as;
      if (!c.last_item) return;
      sat = 0;
      zero = 0;
      a_rms = floor_root(err_sq);
      if (a_rms > ROOT_CAP) begin
         a_rms = ROOT_CAP;
         sat = 1;
      end
      r_rms = floor_root(refsq);
      if (r_rms > ROOT_CAP) begin
         r_rms = ROOT_CAP;
         sat = 1;
      end
      n.abs_sum_err    = err_l1[vpen_pkg::L1_OUT_W-1:0];
      n.abs_rms_err    = a_rms[vpen_pkg::RMS_OUT_W-1:0];
      n.abs_peak_err   = err_peak[vpen_pkg::PEAK_OUT_W-1:0];
      n.rel_sum_err    = ratio(err_l1, refl1, zero);
      n.rel_rms_err    = ratio(a_rms, r_rms, zero);
      n.rel_peak_err   = ratio(err_peak, refpeak, zero);
      n.ref_sum_norm   = refl1[vpen_pkg::L1_OUT_W-1:0];
      n.ref_rms_norm   = r_rms[vpen_pkg::RMS_OUT_W-1:0];
      n.ref_peak_norm  = refpeak[vpen_pkg::PEAK_OUT_W-1:0];
      n.zero_reference = zero;
      n.sum_saturated  = accum_overflow | sat;
      expected_norms.push_back(n);
      err_l1 = 0; err_sq = 0; err_peak = 0;
      refl1 = 0; refsq = 0; refpeak = 0;
      accum_overflow = 0;
   endfunction

   // Driver. A transfer happens at an edge where start is high and busy is
   // low; the cell that was on the ports is then predicted, and the next
   // one (or a gap) is chosen. While busy holds, the current cell stays put.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) accumulate_cell('{req_test_first, req_test_second, req_ref_first,
                                      req_ref_second, req_last_item, 0, 0});
         if (pending_cells.size() != 0 &&
             !(pending_cells[0].drain_first && expected_norms.size() != 0) &&
             (pending_cells[0].no_idle || $urandom_range(0, 99) >= 25)) begin
            req_test_first  <= pending_cells[0].test_first;
            req_test_second <= pending_cells[0].test_second;
            req_ref_first   <= pending_cells[0].ref_first;
            req_ref_second  <= pending_cells[0].ref_second;
            req_last_item   <= pending_cells[0].last_item;
            void'(pending_cells.pop_front());
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Monitor. The receiver cannot stall, so every strobed cycle is a
   // transfer and is compared against the oldest pending expectation.
   always @(posedge clock) begin
      norms_type n;
      if (!reset && rsp_valid) begin
         if (expected_norms.size() == 0) begin
            $error("result transfer with no data set pending");
            mismatch_count++;
         end else begin
            n = expected_norms.pop_front();
            check_field("abs_sum_err", n.abs_sum_err, rsp_abs_sum_err);
            check_field("abs_rms_err", n.abs_rms_err, rsp_abs_rms_err);
            check_field("abs_peak_err", n.abs_peak_err, rsp_abs_peak_err);
            check_field("rel_sum_err", n.rel_sum_err, rsp_rel_sum_err);
            check_field("rel_rms_err", n.rel_rms_err, rsp_rel_rms_err);
            check_field("rel_peak_err", n.rel_peak_err, rsp_rel_peak_err);
            check_field("ref_sum_norm", n.ref_sum_norm, rsp_ref_sum_norm);
            check_field("ref_rms_norm", n.ref_rms_norm, rsp_ref_rms_norm);
            check_field("ref_peak_norm", n.ref_peak_norm, rsp_ref_peak_norm);
            check_field("zero_reference", n.zero_reference, rsp_zero_reference);
            check_field("sum_saturated", n.sum_saturated, rsp_sum_saturated);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [vpen_pkg::IN_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(vpen_pkg::IN_W-1){1'b0}}};
         1: return {1'b0, {(vpen_pkg::IN_W-1){1'b1}}};
         2: return '0;
         3: return vpen_pkg::IN_W'($urandom_range(0, 3)) - vpen_pkg::IN_W'(1);
         default: return vpen_pkg::IN_W'($urandom);
      endcase
   endfunction

   function automatic void add_cell(logic [vpen_pkg::IN_W-1:0] tf,
                                    logic [vpen_pkg::IN_W-1:0] ts,
                                    logic [vpen_pkg::IN_W-1:0] rf,
                                    logic [vpen_pkg::IN_W-1:0] rs,
                                    logic last, bit drain = 0, bit calm = 0);
      pending_cells.push_back('{tf, ts, rf, rs, last, drain, calm});
   endfunction

   initial begin
      logic [vpen_pkg::IN_W-1:0] mx, mn, tf, ts, rf, rs;
      int len, cells;
      bit calm, one_comp;
      mx = {1'b0, {(vpen_pkg::IN_W-1){1'b1}}};
      mn = {1'b1, {(vpen_pkg::IN_W-1){1'b0}}};

      // Directed sets. A set with an all-zero reference divides by zero.
      add_cell('0, '0, '0, '0, 1);
      add_cell(mx, mn, '0, '0, 1);
      // Largest differences in both directions on both components.
      add_cell(mx, mn, mn, mx, 0);
      add_cell(mn, mx, mx, mn, 1);
      // A one-component set, with the second components held at zero.
      add_cell(24'h010000, '0, 24'h008000, '0, 0);
      add_cell(mn, '0, 24'hFF0000, '0, 1);
      // A tiny reference against a large difference overflows the quotients.
      add_cell(mx, mx, 24'd1, '0, 0);
      add_cell(mn, mn, '0, 24'hFFFFFF, 1);
      // Identical test and reference give zero relative errors.
      add_cell(24'h123456, 24'hABCDEF, 24'h123456, 24'hABCDEF, 1, 1);
      add_cell(24'hFFFFFF, 24'd1, 24'd1, 24'hFFFFFF, 1);

      // Random sets, mostly short. One stretch of sets runs without gaps,
      // and now and then the sender waits for all results before a set.
      cells = 0;
      while (cells < 900) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         calm = (cells >= 300 && cells < 450);
         one_comp = ($urandom_range(0, 7) == 0);
         for (int i = 0; i < len; i++) begin
            tf = pick_sample();
            rf = pick_sample();
            ts = one_comp ? '0 : pick_sample();
            rs = one_comp ? '0 : pick_sample();
            add_cell(tf, ts, rf, rs, (i == len - 1),
                     (i == 0 && $urandom_range(0, 29) == 0), calm);
         end
         cells += len;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pending_cells.size() == 0 && !start && expected_norms.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_norms.size() != 0) begin
         $error("%0d data sets never produced a result", expected_norms.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
hdl/vpen_pkg.sv
hdl/vpen_front.sv
hdl/vpen_queue.sv
hdl/vpen_back.sv
hdl/vector_pair_error_norms_top.sv
tb/sv/tb_vector_pair_error_norms_top.sv
